FILE: hw/rtl/pid_controller_deadband_clamped_unit_defines.svh
// ---------------------------------------------------------------------------
// PID controller assertion macros
// Shared macros for the concurrent checks on the PID controller ports.
// ---------------------------------------------------------------------------
`ifndef PID_CONTROLLER_DEADBAND_CLAMPED_UNIT_DEFINES_SVH
`define PID_CONTROLLER_DEADBAND_CLAMPED_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PIDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define PIDC_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/pidc_pkg.sv
// ---------------------------------------------------------------------------
// PID controller package
// Types and constants shared by the stages of the PID controller.
// ---------------------------------------------------------------------------
package pidc_pkg;

  typedef enum logic [1:0] {
    OP_STEP      = 2'd0,
    OP_CLEAR_ALL = 2'd1,
    OP_CLEAR_INT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MODE_P   = 2'd0,
    MODE_PI  = 2'd1,
    MODE_PD  = 2'd2,
    MODE_PID = 2'd3
  } mode_e;

  localparam logic [2:0] REG_GAIN_P    = 3'd0;
  localparam logic [2:0] REG_GAIN_I    = 3'd1;
  localparam logic [2:0] REG_GAIN_D    = 3'd2;
  localparam logic [2:0] REG_OUT_LIM   = 3'd3;
  localparam logic [2:0] REG_INT_LIM   = 3'd4;
  localparam logic [2:0] REG_DEAD_BAND = 3'd5;
  localparam logic [2:0] REG_MODE      = 3'd6;

  localparam logic [14:0] OUT_LIM_RESET = 15'h7FFF;
  // ceil(2^35 / 10): x / 10 == (x * RECIP_TEN) >> 35 for any 32-bit x.
  localparam logic [31:0] RECIP_TEN     = 32'hCCCC_CCCD;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [14:0] out_limit;
    logic [30:0] integral_limit;
    logic [27:0] inc_limit;
    logic [15:0] dead_band;
    mode_e       term_mode;
  } cfg_t;

  typedef struct packed {
    op_e                op;
    logic signed [16:0] err;
    logic signed [17:0] derr;
  } err_stage_t;

  typedef struct packed {
    op_e                op;
    logic signed [25:0] p;
    logic signed [25:0] inc;
    logic signed [26:0] d;
  } term_stage_t;

  typedef struct packed {
    logic signed [25:0] p;
    logic signed [31:0] integ;
    logic signed [26:0] d;
  } int_stage_t;

endpackage

FILE: hw/rtl/pid_controller_deadband_clamped_unit.sv
// ---------------------------------------------------------------------------
// PID controller with dead band and anti-windup
// Fixed-point PID step with dead-banded error, clamped integral and
// saturated output, behind stream-style input and output channels.
// ---------------------------------------------------------------------------
// A new request may follow in every cycle while results are taken at the
// output; a control step gives its drive value through the error,
// multiplier, integral and output stage registers in turn. The
// integral accumulator closes its loop within the integral stage, which is
// what holds the rate at one request per cycle. Reset-all and
// reset-integral requests give no result. The output register holds a
// waiting result, and the stages before it stall once full until it is taken.
// Configuration writes are always accepted and should only be made while the
// block is idle; the integral increment limit is registered from the
// integral limit register after that register takes a write.
module pid_controller_deadband_clamped_unit import pidc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] setpoint, [31:16] measured
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] drive
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  cfg_t               cfg;
  logic               a_valid, a_ready, b_valid, b_ready, c_valid, c_ready;
  err_stage_t         a_data;
  term_stage_t        b_data;
  int_stage_t         c_data;
  logic signed [15:0] drive;

  assign cfg_ready = 1'b1;

  pidc_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pidc_error u_error (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (in_tvalid),
    .up_ready    (in_tready),
    .up_op       (op_e'(in_tuser)),
    .up_setpoint ($signed(in_tdata[15:0])),
    .up_measured ($signed(in_tdata[31:16])),
    .dead_band   (cfg.dead_band),
    .dn_valid    (a_valid),
    .dn_ready    (a_ready),
    .dn_data     (a_data)
  );

  pidc_terms u_terms (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (a_valid),
    .up_ready (a_ready),
    .up_data  (a_data),
    .cfg      (cfg),
    .dn_valid (b_valid),
    .dn_ready (b_ready),
    .dn_data  (b_data)
  );

  pidc_integral u_integral (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (b_valid),
    .up_ready (b_ready),
    .up_data  (b_data),
    .cfg      (cfg),
    .dn_valid (c_valid),
    .dn_ready (c_ready),
    .dn_data  (c_data)
  );

  pidc_output u_output (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (c_valid),
    .up_ready (c_ready),
    .up_data  (c_data),
    .cfg      (cfg),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_drive (drive)
  );

  assign out_tdata = drive;

endmodule

FILE: hw/rtl/pidc_regs.sv
// ---------------------------------------------------------------------------
// PID controller configuration registers
// Holds the gains, limits, dead band and term mode, and derives the
// per-sample integral increment limit.
// ---------------------------------------------------------------------------
module pidc_regs import pidc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  output cfg_t        cfg
);

  logic [15:0] gain_p_r, gain_i_r, gain_d_r, dead_band_r;
  logic [14:0] out_limit_r;
  logic [30:0] int_limit_r;
  logic [27:0] inc_limit_r;
  mode_e       mode_r;
  logic [62:0] recip_prod;

  assign recip_prod = {32'd0, int_limit_r} * {31'd0, RECIP_TEN};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      out_limit_r <= OUT_LIM_RESET;
      int_limit_r <= '0;
      inc_limit_r <= '0;
      dead_band_r <= '0;
      mode_r      <= MODE_PID;
    end else begin
      inc_limit_r <= recip_prod[62:35];
      if (cfg_valid) begin
        case (cfg_index)
          REG_GAIN_P:    gain_p_r    <= cfg_data[15:0];
          REG_GAIN_I:    gain_i_r    <= cfg_data[15:0];
          REG_GAIN_D:    gain_d_r    <= cfg_data[15:0];
          REG_OUT_LIM:   out_limit_r <= cfg_data[14:0];
          REG_INT_LIM:   int_limit_r <= cfg_data;
          REG_DEAD_BAND: dead_band_r <= cfg_data[15:0];
          REG_MODE:      mode_r      <= mode_e'(cfg_data[1:0]);
          default:       ;
        endcase
      end
    end
  end

  always_comb begin
    cfg.gain_p         = gain_p_r;
    cfg.gain_i         = gain_i_r;
    cfg.gain_d         = gain_d_r;
    cfg.out_limit      = out_limit_r;
    cfg.integral_limit = int_limit_r;
    cfg.inc_limit      = inc_limit_r;
    cfg.dead_band      = dead_band_r;
    cfg.term_mode      = mode_r;
  end

endmodule

FILE: hw/rtl/pidc_error.sv
// ---------------------------------------------------------------------------
// PID controller error stage
// Forms the dead-banded error and its change from the previous error.
// ---------------------------------------------------------------------------
module pidc_error import pidc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  op_e                up_op,
  input  logic signed [15:0] up_setpoint,
  input  logic signed [15:0] up_measured,
  input  logic [15:0]        dead_band,
  output logic               dn_valid,
  input  logic               dn_ready,
  output err_stage_t         dn_data
);

  logic               valid_r;
  err_stage_t         data_r, data_nxt;
  logic signed [16:0] prev_err_r;
  logic signed [17:0] diff, db;
  logic signed [16:0] err;
  logic               load, known_op;

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;
  assign known_op = (up_op == OP_STEP) || (up_op == OP_CLEAR_ALL) || (up_op == OP_CLEAR_INT);

  always_comb begin
    diff = 18'(up_setpoint) - 18'(up_measured);
    db   = $signed({2'b00, dead_band});
    if (diff > db) begin
      err = 17'(diff - db);
    end else if (diff < -db) begin
      err = 17'(diff + db);
    end else begin
      err = '0;
    end
    data_nxt.op   = up_op;
    data_nxt.err  = err;
    data_nxt.derr = 18'(err) - 18'(prev_err_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      prev_err_r <= '0;
    end else begin
      if (load) begin
        valid_r <= known_op;
      end else if (dn_ready) begin
        valid_r <= 1'b0;
      end
      if (load && up_op == OP_STEP) begin
        prev_err_r <= err;
      end else if (load && up_op == OP_CLEAR_ALL) begin
        prev_err_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: hw/rtl/pidc_terms.sv
// ---------------------------------------------------------------------------
// PID controller term stage
// Three parallel gain multipliers, each scaled down by 2^8 with floor.
// ---------------------------------------------------------------------------
module pidc_terms import pidc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  err_stage_t  up_data,
  input  cfg_t        cfg,
  output logic        dn_valid,
  input  logic        dn_ready,
  output term_stage_t dn_data
);

  logic               valid_r, load;
  term_stage_t        data_r, data_nxt;
  logic signed [16:0] gp_s, gi_s, gd_s;
  logic signed [33:0] prod_p, prod_i;
  logic signed [34:0] prod_d;

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  always_comb begin
    gp_s          = $signed({1'b0, cfg.gain_p});
    gi_s          = $signed({1'b0, cfg.gain_i});
    gd_s          = $signed({1'b0, cfg.gain_d});
    prod_p        = 34'(gp_s) * 34'(up_data.err);
    prod_i        = 34'(gi_s) * 34'(up_data.err);
    prod_d        = 35'(gd_s) * 35'(up_data.derr);
    data_nxt.op   = up_data.op;
    data_nxt.p    = prod_p[33:8];
    data_nxt.inc  = prod_i[33:8];
    data_nxt.d    = prod_d[34:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (dn_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: hw/rtl/pidc_integral.sv
// ---------------------------------------------------------------------------
// PID controller integral stage
// Clamps the increment, accumulates and clamps the integral (held at zero
// while the integral gain is zero), and carries out the clear requests.
// ---------------------------------------------------------------------------
module pidc_integral import pidc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  term_stage_t up_data,
  input  cfg_t        cfg,
  output logic        dn_valid,
  input  logic        dn_ready,
  output int_stage_t  dn_data
);

  logic               valid_r, load;
  int_stage_t         data_r, data_nxt;
  logic signed [31:0] isum_r, isum_nxt;
  logic signed [29:0] inc_lim, inc_c;
  logic signed [32:0] acc, int_lim;

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  always_comb begin
    inc_lim = $signed({2'b00, cfg.inc_limit});
    if (30'(up_data.inc) > inc_lim) begin
      inc_c = inc_lim;
    end else if (30'(up_data.inc) < -inc_lim) begin
      inc_c = -inc_lim;
    end else begin
      inc_c = 30'(up_data.inc);
    end
    acc     = 33'(isum_r) + 33'(inc_c);
    int_lim = $signed({2'b00, cfg.integral_limit});
    if (cfg.gain_i == 16'd0) begin
      isum_nxt = '0;
    end else if (acc > int_lim) begin
      isum_nxt = 32'(int_lim);
    end else if (acc < -int_lim) begin
      isum_nxt = 32'(-int_lim);
    end else begin
      isum_nxt = 32'(acc);
    end
    data_nxt.p     = up_data.p;
    data_nxt.integ = isum_nxt;
    data_nxt.d     = up_data.d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      isum_r  <= '0;
    end else begin
      if (load) begin
        valid_r <= (up_data.op == OP_STEP);
        if (up_data.op == OP_STEP) begin
          isum_r <= isum_nxt;
        end else begin
          isum_r <= '0;
        end
      end else if (dn_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: hw/rtl/pidc_output.sv
// ---------------------------------------------------------------------------
// PID controller output stage
// Sums the selected terms and saturates the result into the output register.
// ---------------------------------------------------------------------------
module pidc_output import pidc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  int_stage_t         up_data,
  input  cfg_t               cfg,
  output logic               dn_valid,
  input  logic               dn_ready,
  output logic signed [15:0] dn_drive
);

  logic               valid_r, load;
  logic signed [15:0] drive_r, drive_nxt;
  logic signed [33:0] sum, lim;

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  always_comb begin
    case (cfg.term_mode)
      MODE_P:  sum = 34'(up_data.p);
      MODE_PI: sum = 34'(up_data.p) + 34'(up_data.integ);
      MODE_PD: sum = 34'(up_data.p) + 34'(up_data.d);
      default: sum = 34'(up_data.p) + 34'(up_data.integ) + 34'(up_data.d);
    endcase
    lim = $signed({19'd0, cfg.out_limit});
    if (sum > lim) begin
      drive_nxt = 16'(lim);
    end else if (sum < -lim) begin
      drive_nxt = 16'(-lim);
    end else begin
      drive_nxt = 16'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (dn_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive_r <= drive_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_drive = drive_r;

endmodule

FILE: hw/rtl/pidc_checker.sv
// ---------------------------------------------------------------------------
// PID controller port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ---------------------------------------------------------------------------
`include "pid_controller_deadband_clamped_unit_defines.svh"

module pidc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  `PIDC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `PIDC_ASSERT_ALWAYS(a_reset_empty, !rst_n, !out_tvalid, "result valid straight after reset")
  `PIDC_ASSERT_NOW(a_drive_sym, out_tvalid, out_tdata != 16'h8000, "drive outside symmetric limit")
  `PIDC_ASSERT_NOW(a_cfg_taken, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind pid_controller_deadband_clamped_unit pidc_checker u_checker (.*);
